// ----- rtl/ceh_pkg.sv -----
package ceh_pkg;

   typedef enum logic [2:0] {
      CMD_BYTE = 3'd0,
      CMD_LT   = 3'd1,
      CMD_GT   = 3'd2,
      CMD_PAL  = 3'd3,
      CMD_INT  = 3'd4,
      CMD_HEAD = 3'd5,
      CMD_FOOT = 3'd6
   } cmd_type;

   typedef struct packed {
      cmd_type     kind;
      logic [23:0] data;
   } cmd_entry_type;

   localparam logic [1:0]  OP_DATA  = 2'd0;
   localparam logic [1:0]  OP_BEGIN = 2'd1;
   localparam logic [1:0]  OP_END   = 2'd2;

   localparam logic [7:0]  ESC_BYTE    = 8'h19;
   localparam logic [7:0]  SWALLOW_LO  = 8'h1a;
   localparam logic [7:0]  SWALLOW_HI  = 8'h1c;
   localparam logic [16:0] ACC_BAD     = 17'h1ffff;
   localparam logic [23:0] RESET_COLOR = 24'hffffff;

   localparam logic [4:0] LEN_BYTE   = 5'd1;
   localparam logic [4:0] LEN_ENTITY = 5'd4;
   localparam logic [4:0] LEN_FOOT   = 5'd14;
   localparam logic [4:0] LEN_HEAD   = 5'd28;
   localparam logic [4:0] LEN_TAG    = 5'd29;

   localparam logic [7:0] HTML_OPEN [6] = '{"<", "h", "t", "m", "l", ">"};
   localparam logic [7:0] CLOSE_FONT [7] = '{"<", "/", "f", "o", "n", "t", ">"};
   localparam logic [7:0] FONT_OPEN [14] = '{
      "<", "f", "o", "n", "t", " ", "c", "o", "l", "o", "r", "=", "\"", "#"
   };
   localparam logic [7:0] FOOTER [14] = '{
      "<", "/", "f", "o", "n", "t", ">", "<", "/", "h", "t", "m", "l", ">"
   };

   localparam logic [23:0] BASE16 [16] = '{
      24'hc0c0c0, 24'h000000, 24'h808080, 24'h800000,
      24'hff0000, 24'h008000, 24'h00ff80, 24'h808000,
      24'hffff00, 24'h000080, 24'h0000ff, 24'h800080,
      24'hff00ff, 24'h008080, 24'h00ffff, 24'hffffff
   };

   localparam logic [23:0] INTERNAL_RGB [44] = '{
      24'h000066, 24'h000000, 24'h999999, 24'h000000,
      24'hff6633, 24'h990099, 24'h000000, 24'h00cc00,
      24'hcc0000, 24'hcc00ff, 24'h330099, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'hffffff,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h666666,
      24'h9999ff, 24'h3399cc, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000
   };

   function automatic logic [7:0] ceh_cube(input logic [2:0] v);
      ceh_cube = (v == 3'd0) ? 8'd0 : 8'd55 + 8'd40 * {5'd0, v};
   endfunction

   function automatic logic [23:0] ceh_palette(input logic [7:0] idx);
      logic [7:0]  n;
      logic [13:0] p36;
      logic [15:0] p6;
      logic [5:0]  q6;
      logic [11:0] p6b;
      logic [3:0]  q36b;
      logic [2:0]  rv;
      logic [2:0]  gv;
      logic [2:0]  bv;
      logic [7:0]  grey;
      n    = idx - 8'd16;
      p36  = {6'd0, n} * 14'd57;
      rv   = p36[13:11];
      p6   = {8'd0, n} * 16'd171;
      q6   = p6[15:10];
      bv   = 3'(n - 8'({2'd0, q6} * 8'd6));
      p6b  = {6'd0, q6} * 12'd43;
      q36b = p6b[11:8];
      gv   = 3'(q6 - 6'({2'd0, q36b} * 6'd6));
      grey = 8'd8 + 8'((idx - 8'd232) * 8'd10);
      if (idx < 8'd16) begin
         ceh_palette = BASE16[idx[3:0]];
      end else if (idx < 8'd232) begin
         ceh_palette = {ceh_cube(rv), ceh_cube(gv), ceh_cube(bv)};
      end else begin
         ceh_palette = {grey, grey, grey};
      end
   endfunction

   function automatic logic [4:0] ceh_len(input cmd_type kind);
      case (kind)
         CMD_BYTE: ceh_len = LEN_BYTE;
         CMD_LT,
         CMD_GT:   ceh_len = LEN_ENTITY;
         CMD_FOOT: ceh_len = LEN_FOOT;
         CMD_HEAD: ceh_len = LEN_HEAD;
         default:  ceh_len = LEN_TAG;
      endcase
   endfunction

   function automatic logic [7:0] ceh_byte(input cmd_type kind, input logic [4:0] pos,
                                           input logic [23:0] rgb);
      logic [4:0] pre;
      logic [4:0] rel;
      logic [2:0] hi;
      logic [3:0] nib;
      pre = (kind == CMD_HEAD) ? 5'd6 : 5'd7;
      rel = pos - pre;
      hi  = 3'(rel - 5'd14);
      nib = 4'(rgb >> (5'd20 - {hi, 2'b00}));
      case (kind)
         CMD_BYTE: ceh_byte = rgb[7:0];
         CMD_LT,
         CMD_GT: begin
            case (pos[1:0])
               2'd0:    ceh_byte = "&";
               2'd1:    ceh_byte = (kind == CMD_LT) ? "l" : "g";
               2'd2:    ceh_byte = "t";
               default: ceh_byte = ";";
            endcase
         end
         CMD_FOOT: ceh_byte = FOOTER[pos[3:0]];
         default: begin
            if (pos < pre) begin
               ceh_byte = (kind == CMD_HEAD) ? HTML_OPEN[pos[2:0]] : CLOSE_FONT[pos[2:0]];
            end else if (rel < 5'd14) begin
               ceh_byte = FONT_OPEN[rel[3:0]];
            end else if (rel < 5'd20) begin
               ceh_byte = (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h57 + {4'd0, nib};
            end else if (rel == 5'd20) begin
               ceh_byte = "\"";
            end else begin
               ceh_byte = ">";
            end
         end
      endcase
   endfunction

endpackage

// ----- rtl/ceh_front.sv -----
module ceh_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_take,
   input  logic [1:0]             req_opcode,
   input  logic [7:0]             req_in_byte,
   input  logic                   csr_write,
   input  logic [23:0]            csr_default_color,
   output logic                   cmd_push,
   output ceh_pkg::cmd_entry_type cmd_entry
);

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_ESC    = 6'b000010,
      PH_SEL    = 6'b000100,
      PH_ATTR   = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_INT2   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  digits_ff, digits_in;
   logic [16:0] acc_ff, acc_in;
   logic [3:0]  intd_ff, intd_in;
   logic [23:0] color_ff;

   logic        is_dig;
   logic        is_attr;
   logic [3:0]  dval;
   logic [20:0] acc_mul;
   logic [16:0] acc_dig;
   logic [2:0]  dl_base;
   logic [2:0]  dl_dec;
   logic [6:0]  int_idx;

   assign is_dig  = (req_in_byte >= "0") && (req_in_byte <= "9");
   assign is_attr = (req_in_byte == "*") || (req_in_byte == "!") || (req_in_byte == "/")
                    || (req_in_byte == "_") || (req_in_byte == "|");
   assign dval    = 4'(req_in_byte - "0");
   assign acc_mul = {4'd0, acc_ff} * 21'd10 + {17'd0, dval};
   assign acc_dig = (is_dig && acc_ff != ceh_pkg::ACC_BAD)
                    ? ((acc_mul > {4'd0, ceh_pkg::ACC_BAD}) ? ceh_pkg::ACC_BAD : acc_mul[16:0])
                    : ceh_pkg::ACC_BAD;
   assign dl_base = (phase_ff == PH_SEL) ? 3'd2 : digits_ff;
   assign dl_dec  = (dl_base != 3'd0) ? dl_base - 3'd1 : 3'd0;
   assign int_idx = {3'd0, intd_ff} * 7'd10 + {3'd0, dval};

   always_comb begin
      phase_in       = phase_ff;
      digits_in      = digits_ff;
      acc_in         = acc_ff;
      intd_in        = intd_ff;
      cmd_push       = 1'b0;
      cmd_entry.kind = ceh_pkg::CMD_BYTE;
      cmd_entry.data = {16'd0, req_in_byte};
      if (req_take) begin
         case (req_opcode)
            ceh_pkg::OP_BEGIN,
            ceh_pkg::OP_END: begin
               phase_in       = PH_IDLE;
               digits_in      = 3'd0;
               acc_in         = 17'd0;
               intd_in        = 4'd0;
               cmd_push       = 1'b1;
               cmd_entry.kind = (req_opcode == ceh_pkg::OP_BEGIN) ? ceh_pkg::CMD_HEAD
                                                                  : ceh_pkg::CMD_FOOT;
               cmd_entry.data = color_ff;
            end
            ceh_pkg::OP_DATA: begin
               case (phase_ff)
                  PH_ESC: begin
                     if (req_in_byte == "F" || req_in_byte == "*") begin
                        acc_in   = 17'd0;
                        phase_in = PH_SEL;
                     end else if (is_dig) begin
                        intd_in  = dval;
                        phase_in = PH_INT2;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_SEL,
                  PH_ATTR,
                  PH_DIGITS: begin
                     if (phase_ff == PH_SEL && req_in_byte == "@") begin
                        digits_in = 3'd5;
                        phase_in  = PH_ATTR;
                     end else if (phase_ff != PH_DIGITS && is_attr) begin
                        digits_in = dl_base;
                        phase_in  = PH_DIGITS;
                     end else begin
                        acc_in    = acc_dig;
                        digits_in = dl_dec;
                        if (dl_dec == 3'd0) begin
                           phase_in = PH_IDLE;
                           if (acc_dig < 17'd256) begin
                              cmd_push       = 1'b1;
                              cmd_entry.kind = ceh_pkg::CMD_PAL;
                              cmd_entry.data = {7'd0, acc_dig};
                           end
                        end else begin
                           phase_in = PH_DIGITS;
                        end
                     end
                  end
                  PH_INT2: begin
                     phase_in = PH_IDLE;
                     if (is_dig && int_idx < 7'd44) begin
                        cmd_push       = 1'b1;
                        cmd_entry.kind = ceh_pkg::CMD_INT;
                        cmd_entry.data = {17'd0, int_idx};
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (req_in_byte == ceh_pkg::ESC_BYTE) begin
                        phase_in = PH_ESC;
                     end else if (req_in_byte inside {[ceh_pkg::SWALLOW_LO:ceh_pkg::SWALLOW_HI]})
                     begin
                        cmd_push = 1'b0;
                     end else if (req_in_byte == "<") begin
                        cmd_push       = 1'b1;
                        cmd_entry.kind = ceh_pkg::CMD_LT;
                     end else if (req_in_byte == ">") begin
                        cmd_push       = 1'b1;
                        cmd_entry.kind = ceh_pkg::CMD_GT;
                     end else begin
                        cmd_push = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digits_ff <= 3'd0;
         acc_ff    <= 17'd0;
         intd_ff   <= 4'd0;
         color_ff  <= ceh_pkg::RESET_COLOR;
      end else begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         intd_ff   <= intd_in;
         if (csr_write) begin
            color_ff <= csr_default_color;
         end
      end
   end

endmodule

// ----- rtl/ceh_cmdq.sv -----
module ceh_cmdq #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ceh_pkg::cmd_entry_type push_entry,
   input  logic                   pop,
   output ceh_pkg::cmd_entry_type head,
   output logic                   full,
   output logic                   empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ceh_pkg::cmd_entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == CW'(0));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/ceh_back.sv -----
module ceh_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ceh_pkg::cmd_entry_type q_head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_run
);

   logic             cur_valid_ff, cur_valid_in;
   ceh_pkg::cmd_type cur_kind_ff, cur_kind_in;
   logic [23:0]      cur_rgb_ff, cur_rgb_in;
   logic [4:0]       cur_pos_ff, cur_pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic             advance;
   logic             emit;
   logic             at_last;
   logic             load;
   logic [23:0]      head_rgb;

   assign advance = !out_valid_ff || rsp_pop;
   assign emit    = cur_valid_ff && advance;
   assign at_last = (cur_pos_ff == ceh_pkg::ceh_len(cur_kind_ff) - 5'd1);
   assign load    = !cur_valid_ff || (emit && at_last);
   assign q_pop   = load && !q_empty;

   always_comb begin
      case (q_head.kind)
         ceh_pkg::CMD_PAL: head_rgb = ceh_pkg::ceh_palette(q_head.data[7:0]);
         ceh_pkg::CMD_INT: head_rgb = ceh_pkg::INTERNAL_RGB[q_head.data[5:0]];
         default:          head_rgb = q_head.data;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_kind_in  = cur_kind_ff;
      cur_rgb_in   = cur_rgb_ff;
      cur_pos_in   = cur_pos_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_kind_in  = q_head.kind;
         cur_rgb_in   = head_rgb;
         cur_pos_in   = 5'd0;
      end else if (load) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         cur_pos_in = cur_pos_ff + 5'd1;
      end
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = emit;
         out_byte_in  = ceh_pkg::ceh_byte(cur_kind_ff, cur_pos_ff, cur_rgb_ff);
         out_last_in  = at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_rgb_ff  <= cur_rgb_in;
      cur_pos_ff  <= cur_pos_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

// ----- rtl/color_escape_to_html_stream_top.sv -----
// Converts message bytes with color escapes into an HTML byte stream. The front end takes one
// item per cycle while its command queue (CMDQ_DEPTH entries) has room; the back end sends each
// command's bytes in order, stalling while a result byte waits unpopped. A plain byte gives 1
// output byte, "<" or ">" 4, an end marker 14, a begin marker 28 and a color tag 29, and a run
// of long expansions fills the queue and raises full until the back end catches up. Escape
// bytes, swallowed control bytes and invalid escapes produce no output. csr_default_color is
// taken at any time and applies to begin markers accepted afterwards.
module color_escape_to_html_stream_top #(
   parameter int CMDQ_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_in_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_default_color
);

   logic                   req_take;
   logic                   cmd_push;
   ceh_pkg::cmd_entry_type cmd_entry;
   ceh_pkg::cmd_entry_type q_head;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign req_take  = push && !q_full;

   ceh_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_take          (req_take),
      .req_opcode        (req_opcode),
      .req_in_byte       (req_in_byte),
      .csr_write         (csr_valid && csr_ready),
      .csr_default_color (csr_default_color),
      .cmd_push          (cmd_push),
      .cmd_entry         (cmd_entry)
   );

   ceh_cmdq #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_entry (cmd_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   ceh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result side not empty after reset");

endmodule
